@@ rtl/sitda_pkg.sv @@
`timescale 1ns / 1ps
package sitda_pkg;

    localparam int WORD_BITS = 32;
    localparam int MAG_BITS  = WORD_BITS - 1;
    // decimal digits of 2^(WORD_BITS-1): floor(MAG_BITS * log10(2)) + 1
    localparam int DIGITS    = (MAG_BITS * 30103) / 100000 + 1;
    localparam int BCD_BITS  = DIGITS * 4;
    localparam int IDX_BITS  = $clog2(DIGITS);
    // shift-add-3 steps done by one pipeline stage
    localparam int STEP      = 8;
    localparam int NSTAGES   = (WORD_BITS + STEP - 1) / STEP;
    localparam int PAD_BITS  = NSTAGES * STEP;

    localparam logic [5:0] CH_ZERO  = 6'd48;
    localparam logic [5:0] CH_MINUS = 6'd45;

    typedef struct packed {
        logic                neg;
        logic [PAD_BITS-1:0] mag;
        logic [BCD_BITS-1:0] bcd;
    } t_dd;

endpackage

@@ rtl/signed_int_to_decimal_ascii_top.sv @@
`timescale 1ns / 1ps
// Signed integer to decimal ASCII text.
// Input channel: i_valid / o_stall with i_value, a two's-complement word.
// A transaction is taken on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_text_char and o_last. Each input
// gives its decimal text one character per transaction, most significant
// first, a leading '-' for negatives, o_last on the final digit.
// Pipeline: sign/magnitude stage, NSTAGES double-dabble stages (8 bits
// each, 4 at 32 bits), then the character serializer. The first character
// is registered in the serializer after passing the front and dabble stages.
// Throughput: one character per cycle while i_stall is low, 1 to 11
// characters per item at 32 bits; the serializer sets this figure.
// Upstream stages keep accepting while the serializer works, buffering up
// to NSTAGES + 1 items.
// Reset (synchronous, active low) empties every stage; no item survives.
// When i_stall is high the current character and o_last hold; stages fill
// up behind it and o_stall rises once all are full.
module signed_int_to_decimal_ascii_top
    import sitda_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [WORD_BITS-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [5:0]                  o_text_char,
    output logic                        o_last
);

    logic [NSTAGES:0] vld;
    logic [NSTAGES:0] rdy;
    t_dd              dat [NSTAGES+1];
    logic             front_ready;
    logic             ser_ready;

    assign o_stall = !front_ready;

    sitda_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (front_ready),
        .i_value (i_value),
        .o_valid (vld[0]),
        .i_ready (rdy[0]),
        .o_data  (dat[0])
    );

    for (genvar k = 0; k < NSTAGES; k++) begin : g_dd
        sitda_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[k]),
            .o_ready (rdy[k]),
            .i_data  (dat[k]),
            .o_valid (vld[k+1]),
            .i_ready (rdy[k+1]),
            .o_data  (dat[k+1])
        );
    end

    assign rdy[NSTAGES] = ser_ready;

    sitda_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (vld[NSTAGES]),
        .o_ready     (ser_ready),
        .i_data      (dat[NSTAGES]),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_text_char (o_text_char),
        .o_last      (o_last)
    );

endmodule

@@ rtl/sitda_front.sv @@
`timescale 1ns / 1ps
module sitda_front
    import sitda_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [WORD_BITS-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output t_dd                         o_data
);

    logic          r_valid;
    t_dd           r_data;
    t_dd           n_data;
    logic [WORD_BITS-1:0] mag;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // unsigned negate, so the most negative value yields 2^(WORD_BITS-1)
    always_comb begin
        mag = i_value[WORD_BITS-1] ? (~i_value + 1'b1) : i_value;
        n_data.neg = i_value[WORD_BITS-1];
        n_data.mag = PAD_BITS'(mag);
        n_data.bcd = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

@@ rtl/sitda_dabble_stage.sv @@
`timescale 1ns / 1ps
module sitda_dabble_stage
    import sitda_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_dd  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_dd  o_data
);

    logic r_valid;
    t_dd  r_data;
    t_dd  n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // STEP double-dabble iterations: add 3 to digits >= 5, then shift one bit in
    always_comb begin
        logic [BCD_BITS-1:0] b;
        logic [PAD_BITS-1:0] m;
        b = i_data.bcd;
        m = i_data.mag;
        for (int s = 0; s < STEP; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (b[d*4 +: 4] >= 4'd5) begin
                    b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
                end
            end
            b = {b[BCD_BITS-2:0], m[PAD_BITS-1]};
            m = {m[PAD_BITS-2:0], 1'b0};
        end
        n_data.neg = i_data.neg;
        n_data.mag = m;
        n_data.bcd = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

@@ rtl/sitda_serial.sv @@
`timescale 1ns / 1ps
module sitda_serial
    import sitda_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_dd        i_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [5:0] o_text_char,
    output logic       o_last
);

    logic                r_busy;
    logic                r_sign;
    logic [IDX_BITS-1:0] r_pos;
    logic [BCD_BITS-1:0] r_bcd;
    logic [IDX_BITS-1:0] top;
    logic [3:0]          digit;
    logic                take;

    assign take    = r_busy && !i_stall;
    assign o_ready = !r_busy || (take && o_last);
    assign o_valid = r_busy;

    // highest nonzero digit; zero falls back to digit 0
    always_comb begin
        top = '0;
        for (int d = 1; d < DIGITS; d++) begin
            if (i_data.bcd[d*4 +: 4] != 4'd0) begin
                top = IDX_BITS'(d);
            end
        end
    end

    assign digit = r_bcd[r_pos*4 +: 4];

    always_comb begin
        if (r_sign) begin
            o_text_char = CH_MINUS;
            o_last      = 1'b0;
        end else begin
            o_text_char = CH_ZERO + {2'b00, digit};
            o_last      = (r_pos == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sign <= 1'b0;
            r_pos  <= '0;
        end else if (o_ready) begin
            r_busy <= i_valid;
            r_sign <= i_valid && i_data.neg;
            r_pos  <= top;
        end else if (take) begin
            if (r_sign) begin
                r_sign <= 1'b0;
            end else begin
                r_pos <= r_pos - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bcd <= i_data.bcd;
        end
    end

endmodule

@@ tb/itoa_checker.sv @@
`timescale 1ns / 1ps
module itoa_checker
    import sitda_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic signed [WORD_BITS-1:0] i_value,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [5:0]                  i_text_char,
    input  logic                        i_last,
    output int                          o_fail_count,
    output int                          o_chars_due
);

    typedef struct packed {
        logic [5:0] ch;
        logic       last;
    } t_text_char;

    t_text_char pending_text[$];
    int         mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Decimal text of one word: optional '-', then digits MSD first.
    function automatic void push_decimal_text(input logic [WORD_BITS-1:0] word);
        logic                 neg;
        logic [WORD_BITS-1:0] mag;
        logic [3:0]           digit_buf[$];
        t_text_char           c;
        neg = word[WORD_BITS-1];
        // unsigned negate, so the most negative value keeps its magnitude
        mag = neg ? -word : word;
        do begin
            digit_buf.push_front(4'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        if (neg) begin
            c.ch   = CH_MINUS;
            c.last = 1'b0;
            pending_text.push_back(c);
        end
        for (int i = 0; i < digit_buf.size(); i++) begin
            c.ch   = CH_ZERO + 6'(digit_buf[i]);
            c.last = (i == digit_buf.size() - 1);
            pending_text.push_back(c);
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_char want;
        if (!i_rst_n) begin
            pending_text.delete();
        end else begin
            // output side first: a char cannot leave on the edge its input enters
            if (i_out_valid && !i_out_stall) begin
                if (pending_text.size() == 0) begin
                    report($sformatf("unexpected char 0x%0h last=%0b", i_text_char, i_last));
                end else begin
                    want = pending_text.pop_front();
                    if (i_text_char !== want.ch)
                        report($sformatf("char 0x%0h, expected 0x%0h", i_text_char, want.ch));
                    if (i_last !== want.last)
                        report($sformatf("last %0b, expected %0b (char 0x%0h)",
                                         i_last, want.last, want.ch));
                end
            end
            if (i_in_valid && !i_in_stall)
                push_decimal_text(i_value);
        end
        o_chars_due <= pending_text.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import sitda_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * (2 + NSTAGES) + 8;

    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic signed [WORD_BITS-1:0] i_value = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic [5:0]                  o_text_char;
    logic                        o_last;

    int fail_count;
    int chars_due;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;

    signed_int_to_decimal_ascii_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_text_char (o_text_char),
        .o_last      (o_last)
    );

    itoa_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_value      (i_value),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_text_char  (o_text_char),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_chars_due  (chars_due)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d chars outstanding", cycle_count, chars_due);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_value(input logic [WORD_BITS-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
    endtask

    // hold off the sender until every pending char has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (chars_due != 0);
    endtask

    function automatic logic [WORD_BITS-1:0] random_value();
        logic [WORD_BITS-1:0] r;
        r = $urandom;
        case ($urandom_range(3))
            0: r = r % 100;
            1: r = r % 100000;
            2: r = r >> $urandom_range(WORD_BITS - 1);
            default: ;
        endcase
        if ($urandom_range(1)) r = -r;
        return r;
    endfunction

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_value(random_value());
        wait_drained();
    endtask

    initial begin
        logic [WORD_BITS-1:0] directed[$];
        directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                     32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                     -32'sd1000000000, 32'd999999999, 32'd123456789, -32'sd5,
                     32'h5555_5555, 32'haaaa_aaaa, 32'd4294967, -32'sd99999};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_value(directed[i]);
        wait_drained();

        run_phase(0, 0, 80);
        run_phase(86, 0, 80);
        run_phase(0, 86, 80);
        run_phase(29, 29, 90);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ signed_int_to_decimal_ascii_top.f @@
rtl/sitda_pkg.sv
rtl/sitda_front.sv
rtl/sitda_dabble_stage.sv
rtl/sitda_serial.sv
rtl/signed_int_to_decimal_ascii_top.sv
tb/itoa_checker.sv
tb/tb.sv
